@@ rtl/dtp_pkg.sv @@
`timescale 1ns / 1ps

package dtp_pkg;

    // Pool geometry. Node 0 is the root and is never anyone's child.
    localparam int NODE_COUNT  = 131072;
    localparam int DIGIT_RADIX = 10;
    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int DIGIT_W     = 4;
    localparam int REQ_W       = 2;

    // One memory row per node: the child pointers of all digits, lowest
    // digit in the lowest bits, and the terminal flag in the top bit.
    localparam int ROW_W    = DIGIT_RADIX * NODE_W + 1;
    localparam int TERM_BIT = ROW_W - 1;

    typedef logic [NODE_W-1:0]  t_node;
    typedef logic [ROW_W-1:0]   t_row;
    typedef logic [DIGIT_W-1:0] t_digit;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_FIND   = 2'd1,
        REQ_CHECK  = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic  rd_en;
        t_node rd_addr;
        logic  wr_en;
        t_node wr_addr;
        t_row  wr_data;
    } t_mem_req;

    typedef struct packed {
        logic valid;
        logic answer;
        logic table_full;
    } t_result;

endpackage

@@ rtl/dtp_ram.sv @@
`timescale 1ns / 1ps

module dtp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/dtp_ctrl.sv @@
`timescale 1ns / 1ps

module dtp_ctrl import dtp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_valid,
    input  t_req     i_s_req,
    input  t_digit   i_s_digit,
    input  logic     i_s_last,
    output logic     o_s_ready,
    output t_mem_req o_mem,
    input  t_row     i_rd_data,
    input  logic     i_slot_free,
    output t_result  o_res
);

    function automatic t_node get_child(t_row row, t_digit dig);
        t_node c;
        c = '0;
        for (int d = 0; d < DIGIT_RADIX; d++) begin
            if (dig == DIGIT_W'(d)) begin
                c = row[d*NODE_W +: NODE_W];
            end
        end
        return c;
    endfunction

    function automatic t_row set_child(t_row row, t_digit dig, t_node val);
        t_row r;
        r = row;
        for (int d = 0; d < DIGIT_RADIX; d++) begin
            if (dig == DIGIT_W'(d)) begin
                r[d*NODE_W +: NODE_W] = val;
            end
        end
        return r;
    endfunction

    t_state r_state, n_state;
    t_req   r_req;
    t_digit r_digit;
    logic   r_last;
    logic   r_answer, n_answer;
    t_node  r_cursor, n_cursor;
    t_node  r_nodes_used, n_nodes_used;
    logic   r_walk_failed, n_walk_failed;
    logic   r_overflow, n_overflow;
    logic   r_cur_fresh, n_cur_fresh;
    logic   r_root_fresh, n_root_fresh;

    logic   accept;
    t_row   w_row;
    t_node  w_child;
    logic   w_bad_digit;
    logic   w_pool_full;
    logic   w_fail;
    logic   w_overflow;
    logic   w_alloc;
    t_node  w_cursor;
    logic   w_fresh;
    logic   w_wr_en;
    t_row   w_wr_data;
    t_row   f_row;

    assign accept = i_s_valid && o_s_ready;

    // One step of the walk, evaluated on the cursor row in ST_EVAL.
    // A freshly allocated node has never had its row written, so it is
    // taken as all zero and written in full before the cursor leaves it.
    always_comb begin
        w_row       = r_cur_fresh ? '0 : i_rd_data;
        w_child     = get_child(w_row, r_digit);
        w_bad_digit = ({1'b0, r_digit} >= (DIGIT_W+1)'(DIGIT_RADIX));
        w_pool_full = (r_nodes_used >= NODE_W'(NODE_COUNT - 1));
        w_fail      = r_walk_failed;
        w_overflow  = r_overflow;
        w_alloc     = 1'b0;
        w_cursor    = r_cursor;
        w_fresh     = r_cur_fresh;
        w_wr_en     = 1'b0;
        w_wr_data   = '0;
        if (!r_walk_failed) begin
            if (w_bad_digit || (r_req == REQ_CHECK && w_row[TERM_BIT])) begin
                w_fail  = 1'b1;
                w_wr_en = r_cur_fresh;
            end else if (w_child == '0) begin
                if (r_req != REQ_INSERT || w_pool_full) begin
                    w_fail     = 1'b1;
                    w_overflow = r_overflow || (r_req == REQ_INSERT);
                    w_wr_en    = r_cur_fresh;
                end else begin
                    w_alloc   = 1'b1;
                    w_cursor  = r_nodes_used + 1'b1;
                    w_fresh   = 1'b1;
                    w_wr_en   = 1'b1;
                    w_wr_data = set_child(w_row, r_digit, w_cursor);
                end
            end else begin
                w_cursor = w_child;
                w_fresh  = 1'b0;
            end
        end
    end

    // Row of the node reached by the last digit, read back in ST_FIN.
    assign f_row = r_cur_fresh ? '0 : i_rd_data;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_s_req == REQ_CLEAR) ? ST_OUT : ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (w_fail || r_req == REQ_CHECK) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_ready        = 1'b0;
        o_mem            = '0;
        o_res            = '0;
        o_res.answer     = r_answer;
        o_res.table_full = r_overflow;
        n_answer         = r_answer;
        n_cursor         = r_cursor;
        n_nodes_used     = r_nodes_used;
        n_walk_failed    = r_walk_failed;
        n_overflow       = r_overflow;
        n_cur_fresh      = r_cur_fresh;
        n_root_fresh     = r_root_fresh;
        unique case (r_state)
            ST_IDLE: begin
                o_s_ready     = 1'b1;
                o_mem.rd_en   = accept && (i_s_req != REQ_CLEAR);
                o_mem.rd_addr = r_cursor;
                if (accept && i_s_req == REQ_CLEAR) begin
                    n_answer      = 1'b1;
                    n_cursor      = '0;
                    n_nodes_used  = '0;
                    n_walk_failed = 1'b0;
                    n_overflow    = 1'b0;
                    n_cur_fresh   = 1'b1;
                    n_root_fresh  = 1'b1;
                end
            end
            ST_EVAL: begin
                o_mem.wr_en   = w_wr_en;
                o_mem.wr_addr = r_cursor;
                o_mem.wr_data = w_wr_data;
                // The reached node is read now when its flag is needed.
                o_mem.rd_en   = r_last && !w_fail && !w_fresh &&
                                (r_req == REQ_INSERT || r_req == REQ_FIND);
                o_mem.rd_addr = w_cursor;
                n_cursor      = w_cursor;
                n_walk_failed = w_fail;
                n_overflow    = w_overflow;
                n_cur_fresh   = w_fresh;
                n_answer      = !w_fail;
                if (w_alloc) begin
                    n_nodes_used = w_cursor;
                end
                if (w_wr_en && r_cursor == '0) begin
                    n_root_fresh = 1'b0;
                end
            end
            ST_FIN: begin
                if (r_req == REQ_INSERT) begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = r_cursor;
                    o_mem.wr_data = f_row | (t_row'(1) << TERM_BIT);
                    n_cur_fresh   = 1'b0;
                    n_answer      = 1'b1;
                end else begin
                    n_answer      = f_row[TERM_BIT];
                end
            end
            ST_OUT: begin
                if (i_slot_free) begin
                    o_res.valid   = 1'b1;
                    n_cursor      = '0;
                    n_walk_failed = 1'b0;
                    n_overflow    = 1'b0;
                    n_cur_fresh   = r_root_fresh;
                end
            end
            default: begin
                o_s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_cursor      <= '0;
            r_nodes_used  <= '0;
            r_walk_failed <= 1'b0;
            r_overflow    <= 1'b0;
            r_cur_fresh   <= 1'b1;
            r_root_fresh  <= 1'b1;
        end else begin
            r_state       <= n_state;
            r_cursor      <= n_cursor;
            r_nodes_used  <= n_nodes_used;
            r_walk_failed <= n_walk_failed;
            r_overflow    <= n_overflow;
            r_cur_fresh   <= n_cur_fresh;
            r_root_fresh  <= n_root_fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        r_answer <= n_answer;
        if (accept) begin
            r_req   <= i_s_req;
            r_digit <= i_s_digit;
            r_last  <= i_s_last;
        end
    end

`ifndef SYNTHESIS
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem.rd_en && o_mem.wr_en) |-> (o_mem.rd_addr != o_mem.wr_addr))
        else $error("read and write hit the same row in one cycle");

    a_cursor_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_nodes_used)
        else $error("cursor points past the allocated nodes");

    a_alloc_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_nodes_used == $past(r_nodes_used) ||
                  r_nodes_used == NODE_W'($past(r_nodes_used) + 1'b1) ||
                  r_nodes_used == '0))
        else $error("node count moved by more than one");

    a_digit_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_s_req != REQ_CLEAR) |=> (r_state == ST_EVAL))
        else $error("accepted digit did not enter evaluation");
`endif

endmodule

@@ rtl/dtp_out.sv @@
`timescale 1ns / 1ps

module dtp_out import dtp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_result i_res,
    output logic    o_slot_free,
    output logic    o_valid,
    input  logic    i_ready,
    output logic    o_answer,
    output logic    o_table_full
);

    logic r_valid;
    logic r_answer;
    logic r_table_full;

    assign o_slot_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res.valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_answer     <= i_res.answer;
            r_table_full <= i_res.table_full;
        end
    end

    assign o_valid      = r_valid;
    assign o_answer     = r_answer;
    assign o_table_full = r_table_full;

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res.valid |-> o_slot_free)
        else $error("result loaded over a word still waiting");
`endif

endmodule

@@ rtl/digit_trie_prefix_engine.sv @@
`timescale 1ns / 1ps

// Decimal-digit trie over a pool of 131072 nodes, one digit word per input,
// with tlast marking the final digit of a string and tuser choosing insert,
// find, check or clear. The whole trie lives in one 131072 x 171 synchronous
// RAM: each row holds the ten child pointers of a node and its terminal flag.
// In ST_IDLE a digit is taken and the cursor row read; in ST_EVAL the row is
// evaluated and a new child pointer written back. This row read-modify-write
// sets the rate, as the next digit is taken only back in ST_IDLE. The final
// digit of an insert or find whose walk is still good then passes through
// ST_FIN to read or mark the node reached, and every result passes through
// ST_OUT to the output register; a check or a failed walk skips ST_FIN, and
// a clear goes straight to ST_OUT. A result that finds the output register
// still holding an unread word waits until that word is taken, and no new
// digit is accepted meanwhile. Reset and clear act at once with no clearing
// pass: rows of nodes allocated since the last clear are the only ones ever
// read, and a newly allocated node is treated as empty and written in full
// before the walk leaves it. A finished result waits in the output register
// while the next digit is already being taken.
module digit_trie_prefix_engine import dtp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input digit words.
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [3:0] digit, [7:4] zero
    input  logic       i_s_axis_tlast,   // last digit of the string
    input  logic [1:0] i_s_axis_tuser,   // [1:0] req_type
    // Result words.
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata    // [0] answer, [1] table_full, [7:2] zero
);

    t_mem_req mem;
    t_row     rd_data;
    t_result  res;
    logic     slot_free;
    logic     answer;
    logic     table_full;

    dtp_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NODE_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem.wr_en),
        .i_wr_addr (mem.wr_addr),
        .i_wr_data (mem.wr_data),
        .i_rd_en   (mem.rd_en),
        .i_rd_addr (mem.rd_addr),
        .o_rd_data (rd_data)
    );

    // The walk sequencer owns the cursor, the node count and the per-string
    // failure and overflow flags.
    dtp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (i_s_axis_tvalid),
        .i_s_req     (t_req'(i_s_axis_tuser)),
        .i_s_digit   (i_s_axis_tdata[DIGIT_W-1:0]),
        .i_s_last    (i_s_axis_tlast),
        .o_s_ready   (o_s_axis_tready),
        .o_mem       (mem),
        .i_rd_data   (rd_data),
        .i_slot_free (slot_free),
        .o_res       (res)
    );

    dtp_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_res        (res),
        .o_slot_free  (slot_free),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_answer     (answer),
        .o_table_full (table_full)
    );

    assign o_m_axis_tdata = {6'b0, table_full, answer};

endmodule

@@ sim/tb_digit_trie_prefix_engine.sv @@
`timescale 1ns / 1ps

module tb_digit_trie_prefix_engine import dtp_pkg::*;;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_WORDS = 1350;

    typedef struct packed {
        logic answer;
        logic table_full;
    } t_trie_reply;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_axis_tvalid;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata;
    logic       i_s_axis_tlast;
    logic [1:0] i_s_axis_tuser;
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready;
    logic [7:0] o_m_axis_tdata;

    digit_trie_prefix_engine i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Mirror of the trie. Only allocated child slots and set terminal
    // flags are stored, so an absent key means zero.
    int unsigned mirror_kids [int unsigned];
    bit          mirror_term [int unsigned];
    int unsigned mirror_nodes;
    int unsigned mirror_cursor;
    bit          mirror_broken;
    bit          mirror_overflow;

    t_trie_reply pending_replies[$];
    t_trie_reply want_reply;
    int          error_count = 0;
    int          reply_index = 0;
    int          cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic flag_error(string msg);
        if (error_count < 10) $display("mismatch: %s", msg);
        error_count++;
    endtask

    // Walks one digit word through the mirror and queues the reply it causes.
    task automatic trie_walk(t_req req, t_digit dig, logic lst);
        int unsigned slot;
        int unsigned kid;
        t_trie_reply reply;
        if (req == REQ_CLEAR) begin
            mirror_kids.delete();
            mirror_term.delete();
            mirror_nodes    = 0;
            mirror_cursor   = 0;
            mirror_broken   = 1'b0;
            mirror_overflow = 1'b0;
            reply.answer     = 1'b1;
            reply.table_full = 1'b0;
            pending_replies.insert(pending_replies.size(), reply);
            return;
        end
        if (!mirror_broken) begin
            if (dig >= DIGIT_RADIX) begin
                mirror_broken = 1'b1;
            end else if (req == REQ_CHECK && mirror_term.exists(mirror_cursor)) begin
                // A stored string is a proper prefix of this one.
                mirror_broken = 1'b1;
            end else begin
                slot = mirror_cursor * DIGIT_RADIX + dig;
                kid  = mirror_kids.exists(slot) ? mirror_kids[slot] : 0;
                if (kid == 0) begin
                    if (req != REQ_INSERT) begin
                        mirror_broken = 1'b1;
                    end else if (mirror_nodes >= NODE_COUNT - 1) begin
                        mirror_overflow = 1'b1;
                        mirror_broken   = 1'b1;
                    end else begin
                        mirror_nodes++;
                        kid = mirror_nodes;
                        mirror_kids[slot] = kid;
                    end
                end
                if (!mirror_broken) mirror_cursor = kid;
            end
        end
        if (!lst) return;
        if (req == REQ_INSERT) begin
            if (!mirror_broken) mirror_term[mirror_cursor] = 1'b1;
            reply.answer = !mirror_broken;
        end else if (req == REQ_FIND) begin
            reply.answer = !mirror_broken && mirror_term.exists(mirror_cursor);
        end else begin
            reply.answer = !mirror_broken;
        end
        reply.table_full = mirror_overflow;
        pending_replies.insert(pending_replies.size(), reply);
        mirror_cursor   = 0;
        mirror_broken   = 1'b0;
        mirror_overflow = 1'b0;
    endtask

    // Offers one digit word, waits for it to be taken, then predicts it.
    task automatic send_digit(t_req req, t_digit dig, logic lst);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {4'b0000, dig};
        i_s_axis_tuser  = req;
        i_s_axis_tlast  = lst;
        do @(posedge i_clk); while (!o_s_axis_tready);
        trie_walk(req, dig, lst);
    endtask

    // Digits are read left to right from the hex literal.
    task automatic send_string(t_req req, logic [63:0] digs, int len);
        for (int i = 0; i < len; i++)
            send_digit(req, t_digit'(digs[4*(len-1-i) +: 4]), i == len - 1);
    endtask

    // Stops offering words and waits until every queued reply has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    // Result side: random backpressure on its own schedule.
    initial begin : drive_ready
        int hold;
        hold = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold == 0) begin
                i_m_axis_tready = 1'b1;
                if ($urandom_range(0, 3) == 0) hold = pick_gap();
            end else begin
                i_m_axis_tready = 1'b0;
                hold--;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_replies.size() == 0) begin
                flag_error($sformatf("reply %0d arrived with nothing expected", reply_index));
            end else begin
                want_reply = pending_replies.pop_front();
                if (o_m_axis_tdata[0] !== want_reply.answer)
                    flag_error($sformatf("reply %0d answer expected %0b got %0b",
                        reply_index, want_reply.answer, o_m_axis_tdata[0]));
                if (o_m_axis_tdata[1] !== want_reply.table_full)
                    flag_error($sformatf("reply %0d table_full expected %0b got %0b",
                        reply_index, want_reply.table_full, o_m_axis_tdata[1]));
            end
            reply_index++;
        end
    end

    task automatic test_each_request();
        send_digit(REQ_CLEAR, 4'd0, 1'b1);
        send_string(REQ_FIND, 64'h5, 1);      // empty trie
        send_string(REQ_INSERT, 64'h0, 1);
        send_string(REQ_INSERT, 64'h99, 2);
        send_string(REQ_FIND, 64'h99, 2);
        send_string(REQ_FIND, 64'h9, 1);      // node exists but is not terminal
        send_string(REQ_CHECK, 64'h45, 2);    // missing child
    endtask

    task automatic test_prefix_and_mixing();
        send_string(REQ_CHECK, 64'h05, 2);    // "0" is stored
        send_string(REQ_CHECK, 64'h991, 3);   // "99" is stored
        // Insert steps down, then a find digit on a missing child ends it.
        send_digit(REQ_INSERT, 4'd7, 1'b0);
        send_digit(REQ_FIND, 4'd7, 1'b1);
    endtask

    task automatic test_bad_digits();
        send_string(REQ_INSERT, 64'h1F, 2);
        send_string(REQ_FIND, 64'hA, 1);
        send_string(REQ_CHECK, 64'h9E, 2);
    endtask

    task automatic test_clear_midstring();
        send_digit(REQ_INSERT, 4'd3, 1'b0);
        send_digit(REQ_CLEAR, 4'hF, 1'b0);
        send_string(REQ_FIND, 64'h99, 2);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        logic [63:0] saved_digs [16];
        int          saved_len [16];
        int          saved_count;
        int          saved_next;
        int          sent;
        int          next_pause;
        int          len;
        int          pick;
        int          trim;
        int          r;
        logic [63:0] digs;
        t_req        req;
        t_req        step_req;
        saved_count = 0;
        saved_next  = 0;
        sent        = 0;
        next_pause  = 300;
        while (sent < RANDOM_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_digit(REQ_CLEAR, t_digit'($urandom_range(0, 15)),
                    logic'($urandom_range(0, 1)));
                sent++;
            end else if (r < 12) begin
                // Noise: any request but clear, any digit code.
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    send_digit(t_req'($urandom_range(0, 2)),
                        t_digit'($urandom_range(0, 15)), i == len - 1);
                sent += len;
            end else begin
                if (saved_count > 0 && $urandom_range(0, 2) != 0) begin
                    pick = $urandom_range(0, saved_count - 1);
                    digs = saved_digs[pick];
                    len  = saved_len[pick];
                    case ($urandom_range(0, 3))
                        0: if (len > 1) begin
                            trim = $urandom_range(1, len - 1);
                            digs = digs >> (4 * trim);
                            len  = len - trim;
                        end
                        1: if (len < 16) begin
                            digs = (digs << 4) | 64'($urandom_range(0, 9));
                            len++;
                        end
                        default: ;
                    endcase
                end else begin
                    len  = $urandom_range(1, 6);
                    digs = '0;
                    for (int i = 0; i < len; i++)
                        digs = (digs << 4) | 64'(($urandom_range(0, 4) == 0) ?
                            $urandom_range(0, 9) : $urandom_range(0, 2));
                end
                // Now and then an out-of-range digit breaks the string.
                if ($urandom_range(0, 19) == 0)
                    digs[4*$urandom_range(0, len - 1) +: 4] = 4'($urandom_range(10, 15));
                r = $urandom_range(0, 9);
                req = (r < 4) ? REQ_INSERT : (r < 7) ? REQ_FIND : REQ_CHECK;
                for (int i = 0; i < len; i++) begin
                    step_req = ($urandom_range(0, 9) == 0) ?
                        t_req'($urandom_range(0, 2)) : req;
                    send_digit(step_req, t_digit'(digs[4*(len-1-i) +: 4]), i == len - 1);
                end
                if (req == REQ_INSERT) begin
                    saved_digs[saved_next] = digs;
                    saved_len[saved_next]  = len;
                    saved_next = (saved_next + 1) % 16;
                    if (saved_count < 16) saved_count++;
                end
                sent += len;
            end
            if (sent >= next_pause) begin
                wait_drained();
                next_pause += 300;
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'h00;
        i_s_axis_tlast  = 1'b0;
        i_s_axis_tuser  = REQ_INSERT;
        mirror_nodes    = 0;
        mirror_cursor   = 0;
        mirror_broken   = 1'b0;
        mirror_overflow = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_each_request();
        test_prefix_and_mixing();
        test_bad_digits();
        test_clear_midstring();
        test_random_traffic();

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
